// File: hw/rtl/mexp_pkg.sv
// shared types, constants and sequencer states of the modular exponentiation unit
package mexp_pkg;

    // port width of every data field and configuration value
    localparam int FIELD_BITS   = 64;
    // datapath word width, capped at the field width
    localparam int WORD_BITS    = 64;
    localparam int DATA_W       = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;
    localparam int CNT_W        = (DATA_W > 1) ? $clog2(DATA_W) : 1;
    localparam int CFG_IDX_BITS = 8;

    typedef logic [DATA_W-1:0]       t_word;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    // configuration register indexes
    localparam t_cfg_idx REG_MODULUS  = t_cfg_idx'(0);
    localparam t_cfg_idx REG_EXPONENT = t_cfg_idx'(1);

    // configuration reset values
    localparam t_word MODULUS_RST  = t_word'(1);
    localparam t_word EXPONENT_RST = t_word'(65537);

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } t_state;

    // request to the shared modular multiplier
    typedef struct packed {
        logic  start;
        t_word a;
        t_word b;
    } t_mm_req;

    // response of the shared modular multiplier
    typedef struct packed {
        logic  done;
        t_word prod;
    } t_mm_rsp;

    // finished result from the sequencer
    typedef struct packed {
        logic  valid;
        t_word value;
    } t_res;

endpackage

// File: hw/rtl/modular_exponentiation_unit.sv
// top level of the modular exponentiation unit: config registers, sequencer, result register
//
//  channel  direction  handshake                 payload
//  cfg      in         i_cfg_valid/o_cfg_ready   i_cfg_index, i_cfg_data
//  in       in         i_in_valid/o_in_ready     i_base_value
//  out      out        o_out_valid/i_out_ready   o_power_result
//
// one request at a time; each modular multiply runs in the
// shared bit-serial multiplier, so a request takes
// 1 + set exponent bits + squarings modular multiplies
// reset (synchronous, active low) sets modulus to 1 and exponent to 65537
// the result register frees the sequencer: a new request is taken while a result waits,
// and a finished result stalls only while the result register is still full
module modular_exponentiation_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  mexp_pkg::t_cfg_idx             i_cfg_index,
    input  logic [mexp_pkg::FIELD_BITS-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [mexp_pkg::FIELD_BITS-1:0] i_base_value,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [mexp_pkg::FIELD_BITS-1:0] o_power_result
);
    import mexp_pkg::*;

    t_word   r_modulus;
    t_word   r_exponent;
    logic    r_out_valid;
    t_word   r_out_data;
    logic    w_out_free;
    t_mm_req w_mm_req;
    t_mm_rsp w_mm_rsp;
    t_res    w_res;

    // config writes must arrive only while idle; the block does not enforce this and is always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= MODULUS_RST;
            r_exponent <= EXPONENT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MODULUS:  r_modulus  <= i_cfg_data[DATA_W-1:0];
                REG_EXPONENT: r_exponent <= i_cfg_data[DATA_W-1:0];
                default: ;
            endcase
        end
    end

    // shared modular multiplier; modulus zero gives plain wrapping products
    mexp_mulmod u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_modulus (r_modulus),
        .i_req     (w_mm_req),
        .o_rsp     (w_mm_rsp)
    );

    // reduce the base, then walk exponent bits from lsb upward
    mexp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_exponent (r_exponent),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_base     (i_base_value[DATA_W-1:0]),
        .o_mm_req   (w_mm_req),
        .i_mm_rsp   (w_mm_rsp),
        .o_res      (w_res),
        .i_out_free (w_out_free)
    );

    // result register
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_res.valid) begin
            r_out_data <= w_res.value;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_power_result = FIELD_BITS'(r_out_data);

    // accepted request makes the sequencer busy next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("sequencer still ready after accepting a request");

    // multiplier only finishes while a request is in work
    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mm_rsp.done |-> !o_in_ready)
        else $error("multiplier finished while sequencer idle");

    // result register fills only from a finished sequencer result
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_res.valid))
        else $error("result valid without a finished request");

endmodule

// File: hw/rtl/mexp_mulmod.sv
// shared bit-serial modular multiplier: one multiplier bit per cycle
module mexp_mulmod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mexp_pkg::t_word   i_modulus,
    input  mexp_pkg::t_mm_req i_req,
    output mexp_pkg::t_mm_rsp o_rsp
);
    import mexp_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_word            r_acc;
    t_word            r_a;
    t_word            r_bits;
    t_word            w_dbl;
    t_word            w_step;

    // (x + y) mod m for x, y below m; modulus zero wraps
    function automatic t_word add_mod(input t_word x, input t_word y, input t_word m);
        logic [DATA_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s[DATA_W] || (s[DATA_W-1:0] >= m)) begin
            return s[DATA_W-1:0] - m;
        end
        return s[DATA_W-1:0];
    endfunction

    // double, then add a when the current multiplier bit is set
    always_comb begin
        w_dbl  = add_mod(r_acc, r_acc, i_modulus);
        w_step = r_bits[DATA_W-1] ? add_mod(w_dbl, r_a, i_modulus) : w_dbl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DATA_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc  <= '0;
            r_a    <= i_req.a;
            r_bits <= i_req.b;
        end else if (r_busy) begin
            r_acc  <= w_step;
            r_bits <= r_bits << 1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule

// File: hw/rtl/mexp_ctrl.sv
// square-and-multiply sequencer driving the shared modular multiplier
module mexp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mexp_pkg::t_word   i_exponent,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mexp_pkg::t_word   i_base,
    output mexp_pkg::t_mm_req o_mm_req,
    input  mexp_pkg::t_mm_rsp i_mm_rsp,
    output mexp_pkg::t_res    o_res,
    input  logic              i_out_free
);
    import mexp_pkg::*;

    t_state r_state;
    t_state n_state;
    t_word  r_e;
    t_word  r_b;
    t_word  r_r;
    t_word  w_half;
    logic   w_e_zero;
    logic   w_half_zero;

    assign w_half      = r_e >> 1;
    assign w_e_zero    = (r_e == '0);
    assign w_half_zero = (w_half == '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_REDUCE;
                end
            end
            ST_REDUCE, ST_SQR: begin
                if (i_mm_rsp.done) begin
                    if (w_e_zero) begin
                        n_state = ST_DONE;
                    end else if (r_e[0]) begin
                        n_state = ST_MUL;
                    end else begin
                        n_state = ST_SQR;
                    end
                end
            end
            ST_MUL: begin
                if (i_mm_rsp.done) begin
                    n_state = w_half_zero ? ST_DONE : ST_SQR;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and multiplier requests
    always_comb begin
        o_in_ready     = 1'b0;
        o_mm_req.start = 1'b0;
        o_mm_req.a     = i_mm_rsp.prod;
        o_mm_req.b     = i_mm_rsp.prod;
        o_res.valid    = 1'b0;
        o_res.value    = r_r;
        unique case (r_state)
            ST_IDLE: begin
                // base reduction is a multiply by one
                o_in_ready     = 1'b1;
                o_mm_req.start = i_in_valid;
                o_mm_req.a     = t_word'(1);
                o_mm_req.b     = i_base;
            end
            ST_REDUCE, ST_SQR: begin
                o_mm_req.start = i_mm_rsp.done && !w_e_zero;
                if (r_e[0]) begin
                    o_mm_req.a = r_r;
                end
            end
            ST_MUL: begin
                o_mm_req.start = i_mm_rsp.done && !w_half_zero;
                o_mm_req.a     = r_b;
                o_mm_req.b     = r_b;
            end
            ST_DONE: begin
                o_res.valid = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    r_e <= i_exponent;
                    r_r <= t_word'(1);
                end
            end
            ST_REDUCE, ST_SQR: begin
                if (i_mm_rsp.done) begin
                    r_b <= i_mm_rsp.prod;
                    // clear bit: drop it now, square next
                    if (!w_e_zero && !r_e[0]) begin
                        r_e <= w_half;
                    end
                end
            end
            ST_MUL: begin
                if (i_mm_rsp.done) begin
                    r_r <= i_mm_rsp.prod;
                    r_e <= w_half;
                end
            end
            default: ;
        endcase
    end

endmodule
